### rtl/osd_pkg.sv
// osd_pkg: shared types and constants of the optimizer stop detector
`timescale 1ns / 1ps

package osd_pkg;

   localparam int GEN_WIDTH       = 16;
   localparam int MASK_WIDTH      = 7;
   localparam int ABS_TOL_WIDTH   = 31;
   localparam int REL_TOL_WIDTH   = 16;
   localparam int REL_FRAC_BITS   = 16;
   localparam int LIMIT_WIDTH     = 16;
   localparam int TARGET_WIDTH    = 32;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int REASON_WIDTH    = 3;

   localparam int QUEUE_DEPTH       = 8;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // enable mask bit positions
   localparam int EN_GENERATIONS = 0;
   localparam int EN_AVG_STALL   = 1;
   localparam int EN_BEST_STALL  = 2;
   localparam int EN_AVG_REL     = 3;
   localparam int EN_BEST_REL    = 4;
   localparam int EN_UPPER       = 5;
   localparam int EN_LOWER       = 6;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE_MASK     = 3'd0,
      CSR_MAX_GENERATIONS = 3'd1,
      CSR_ABS_TOLERANCE   = 3'd2,
      CSR_REL_TOLERANCE   = 3'd3,
      CSR_STALL_LIMIT     = 3'd4,
      CSR_UPPER_TARGET    = 3'd5,
      CSR_LOWER_TARGET    = 3'd6
   } csr_index_type;

   typedef enum logic [REASON_WIDTH-1:0] {
      REASON_CONTINUE    = 3'd0,
      REASON_GENERATIONS = 3'd1,
      REASON_AVG_STALL   = 3'd2,
      REASON_BEST_STALL  = 3'd3,
      REASON_AVG_REL     = 3'd4,
      REASON_BEST_REL    = 3'd5,
      REASON_UPPER       = 3'd6,
      REASON_LOWER       = 3'd7
   } reason_type;

   typedef struct packed {
      logic [MASK_WIDTH-1:0]    enable_mask;
      logic [GEN_WIDTH-1:0]     max_generations;
      logic [ABS_TOL_WIDTH-1:0] abs_tolerance;
      logic [REL_TOL_WIDTH-1:0] rel_tolerance;
      logic [LIMIT_WIDTH-1:0]   stall_limit;
      logic [TARGET_WIDTH-1:0]  upper_target;
      logic [TARGET_WIDTH-1:0]  lower_target;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic cmd;
      logic gen_hit;
      logic avg_abs_stall;
      logic best_abs_stall;
      logic avg_rel_stall;
      logic best_rel_stall;
      logic upper_hit;
      logic lower_hit;
   } flags_type;

endpackage

### rtl/osd_if.sv
// osd_if: valid/ready channel interfaces for items and results
`timescale 1ns / 1ps

interface osd_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [15:0]                   generation;
   logic signed [VALUE_WIDTH-1:0] old_best;
   logic signed [VALUE_WIDTH-1:0] new_best;
   logic signed [VALUE_WIDTH-1:0] old_average;
   logic signed [VALUE_WIDTH-1:0] new_average;

   modport source (
      output valid, cmd, generation, old_best, new_best, old_average, new_average,
      input  ready
   );
   modport sink (
      input  valid, cmd, generation, old_best, new_best, old_average, new_average,
      output ready
   );
endinterface

interface osd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] stop_reason;

   modport source (
      output valid, stop_reason,
      input  ready
   );
   modport sink (
      input  valid, stop_reason,
      output ready
   );
endinterface

### rtl/optimizer_stop_detector.sv
// optimizer_stop_detector: top level with control registers, front, queue and back
//
//   channel  direction  handshake           payload
//   req_bus  in         valid/ready         cmd, generation, old/new best, old/new average
//   rsp_bus  out        valid/ready         stop_reason
//   csr_*    in         csr_write_enable    csr_index, csr_write_data
//
// one item per cycle sustained while the credit window keeps req_bus ready
// the path is two classify stages (subtract; magnitude and multiply), a compare, one queue slot, one result register
// reset clears the stall counters, the queue and the credit count, and loads register defaults
// an eight-entry credit window bounds items in flight; a stalled rsp_bus fills it, then req_bus stalls
`timescale 1ns / 1ps

module optimizer_stop_detector import osd_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   osd_req_if.sink                    req_bus,
   osd_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type   cfg_ff;
   logic      push;
   flags_type push_entry;
   logic      head_valid;
   flags_type head_entry;
   logic      pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_mask     <= MASK_WIDTH'(1);
         cfg_ff.max_generations <= GEN_WIDTH'(1000);
         cfg_ff.abs_tolerance   <= ABS_TOL_WIDTH'(65);
         cfg_ff.rel_tolerance   <= REL_TOL_WIDTH'(66);
         cfg_ff.stall_limit     <= LIMIT_WIDTH'(50);
         cfg_ff.upper_target    <= {1'b0, {(TARGET_WIDTH-1){1'b1}}};
         cfg_ff.lower_target    <= {1'b1, {(TARGET_WIDTH-1){1'b0}}};
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE_MASK: begin
               cfg_ff.enable_mask <= csr_write_data[MASK_WIDTH-1:0];
            end
            CSR_MAX_GENERATIONS: begin
               cfg_ff.max_generations <= csr_write_data[GEN_WIDTH-1:0];
            end
            CSR_ABS_TOLERANCE: begin
               cfg_ff.abs_tolerance <= csr_write_data[ABS_TOL_WIDTH-1:0];
            end
            CSR_REL_TOLERANCE: begin
               cfg_ff.rel_tolerance <= csr_write_data[REL_TOL_WIDTH-1:0];
            end
            CSR_STALL_LIMIT: begin
               cfg_ff.stall_limit <= csr_write_data[LIMIT_WIDTH-1:0];
            end
            CSR_UPPER_TARGET: begin
               cfg_ff.upper_target <= csr_write_data[TARGET_WIDTH-1:0];
            end
            CSR_LOWER_TARGET: begin
               cfg_ff.lower_target <= csr_write_data[TARGET_WIDTH-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   osd_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req          (req_bus),
      .release_item (pop),
      .push         (push),
      .push_entry   (push_entry)
   );

   osd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   osd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

### rtl/osd_front.sv
// osd_front: accepts items and classifies them in a two-stage pipeline
`timescale 1ns / 1ps

module osd_front import osd_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   osd_req_if.sink    req,
   input  logic       release_item,
   output logic       push,
   output flags_type  push_entry
);

   localparam int ABS_CMP_WIDTH =
      (VALUE_WIDTH > ABS_TOL_WIDTH) ? VALUE_WIDTH : ABS_TOL_WIDTH;
   localparam int TGT_CMP_WIDTH =
      (VALUE_WIDTH > TARGET_WIDTH) ? VALUE_WIDTH : TARGET_WIDTH;
   localparam int PROD_WIDTH = VALUE_WIDTH + REL_TOL_WIDTH;

   logic accept;
   logic [QUEUE_COUNT_WIDTH-1:0] pending_ff, pending_in;

   // stage 1
   logic                          s1_valid_ff;
   flags_type                     s1_flags_ff, s1_flags_in;
   logic signed [VALUE_WIDTH:0]   s1_avg_diff_ff, s1_avg_diff_in;
   logic signed [VALUE_WIDTH:0]   s1_best_diff_ff, s1_best_diff_in;
   logic [VALUE_WIDTH-1:0]        s1_avg_mag_ff, s1_avg_mag_in;
   logic [VALUE_WIDTH-1:0]        s1_best_mag_ff, s1_best_mag_in;
   logic signed [TGT_CMP_WIDTH-1:0] nb_ext, upper_ext, lower_ext;

   // stage 2
   logic                    s2_valid_ff;
   flags_type               s2_flags_ff;
   logic [VALUE_WIDTH-1:0]  s2_avg_abs_ff, s2_avg_abs_in;
   logic [VALUE_WIDTH-1:0]  s2_best_abs_ff, s2_best_abs_in;
   logic [PROD_WIDTH-1:0]   s2_avg_prod_ff, s2_avg_prod_in;
   logic [PROD_WIDTH-1:0]   s2_best_prod_ff, s2_best_prod_in;

   // credits cover both stages and the queue
   assign req.ready = (pending_ff < QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign accept    = req.valid && req.ready;

   always_comb begin
      pending_in = pending_ff;
      if (accept && !release_item) begin
         pending_in = pending_ff + QUEUE_COUNT_WIDTH'(1);
      end else if (!accept && release_item) begin
         pending_in = pending_ff - QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      nb_ext    = TGT_CMP_WIDTH'(req.new_best);
      upper_ext = TGT_CMP_WIDTH'($signed(cfg.upper_target));
      lower_ext = TGT_CMP_WIDTH'($signed(cfg.lower_target));

      s1_flags_in           = '0;
      s1_flags_in.cmd       = req.cmd;
      s1_flags_in.gen_hit   = (req.generation >= cfg.max_generations);
      s1_flags_in.upper_hit = (nb_ext >= upper_ext);
      s1_flags_in.lower_hit = (lower_ext >= nb_ext);

      s1_avg_diff_in  = (VALUE_WIDTH+1)'(req.old_average) - (VALUE_WIDTH+1)'(req.new_average);
      s1_best_diff_in = (VALUE_WIDTH+1)'(req.old_best) - (VALUE_WIDTH+1)'(req.new_best);
      s1_avg_mag_in   = req.old_average[VALUE_WIDTH-1] ? VALUE_WIDTH'(-req.old_average)
                                                       : VALUE_WIDTH'(req.old_average);
      s1_best_mag_in  = req.old_best[VALUE_WIDTH-1] ? VALUE_WIDTH'(-req.old_best)
                                                    : VALUE_WIDTH'(req.old_best);
   end

   always_comb begin
      s2_avg_abs_in   = s1_avg_diff_ff[VALUE_WIDTH] ? VALUE_WIDTH'(-s1_avg_diff_ff)
                                                    : VALUE_WIDTH'(s1_avg_diff_ff);
      s2_best_abs_in  = s1_best_diff_ff[VALUE_WIDTH] ? VALUE_WIDTH'(-s1_best_diff_ff)
                                                     : VALUE_WIDTH'(s1_best_diff_ff);
      s2_avg_prod_in  = PROD_WIDTH'(cfg.rel_tolerance) * PROD_WIDTH'(s1_avg_mag_ff);
      s2_best_prod_in = PROD_WIDTH'(cfg.rel_tolerance) * PROD_WIDTH'(s1_best_mag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_flags_ff     <= s1_flags_in;
      s1_avg_diff_ff  <= s1_avg_diff_in;
      s1_best_diff_ff <= s1_best_diff_in;
      s1_avg_mag_ff   <= s1_avg_mag_in;
      s1_best_mag_ff  <= s1_best_mag_in;
      s2_flags_ff     <= s1_flags_ff;
      s2_avg_abs_ff   <= s2_avg_abs_in;
      s2_best_abs_ff  <= s2_best_abs_in;
      s2_avg_prod_ff  <= s2_avg_prod_in;
      s2_best_prod_ff <= s2_best_prod_in;
   end

   always_comb begin
      push_entry = s2_flags_ff;
      push_entry.avg_abs_stall  =
         ABS_CMP_WIDTH'(s2_avg_abs_ff) < ABS_CMP_WIDTH'(cfg.abs_tolerance);
      push_entry.best_abs_stall =
         ABS_CMP_WIDTH'(s2_best_abs_ff) < ABS_CMP_WIDTH'(cfg.abs_tolerance);
      // |diff| * 65536 < tol * |old|
      push_entry.avg_rel_stall  =
         {s2_avg_abs_ff, {REL_FRAC_BITS{1'b0}}} < s2_avg_prod_ff;
      push_entry.best_rel_stall =
         {s2_best_abs_ff, {REL_FRAC_BITS{1'b0}}} < s2_best_prod_ff;
   end

   assign push = s2_valid_ff;

endmodule

### rtl/osd_queue.sv
// osd_queue: short queue of classified items between front and back
`timescale 1ns / 1ps

module osd_queue import osd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  flags_type push_entry,
   input  logic      pop,
   output logic      head_valid,
   output flags_type head_entry
);

   flags_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign do_push = push && (count_ff < QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_COUNT_WIDTH'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QUEUE_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_WIDTH'(1);
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

endmodule

### rtl/osd_back.sv
// osd_back: stall counters, priority decision and result register
`timescale 1ns / 1ps

module osd_back import osd_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      head_valid,
   input  flags_type head_entry,
   output logic      pop,
   osd_rsp_if.source rsp
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

   logic [COUNT_WIDTH-1:0] avg_cnt_ff, avg_cnt_in;
   logic [COUNT_WIDTH-1:0] best_cnt_ff, best_cnt_in;
   logic [COUNT_WIDTH-1:0] avg_rel_cnt_ff, avg_rel_cnt_in;
   logic [COUNT_WIDTH-1:0] best_rel_cnt_ff, best_rel_cnt_in;
   logic                   rsp_valid_ff;
   reason_type             reason_ff, reason_in;
   logic                   go;

   function automatic logic [COUNT_WIDTH-1:0] stall_next(
      input logic [COUNT_WIDTH-1:0] cnt,
      input logic                   stalled
   );
      logic [COUNT_WIDTH-1:0] res;
      res = '0;
      if (stalled) begin
         res = (cnt == '1) ? cnt : cnt + COUNT_WIDTH'(1);
      end
      return res;
   endfunction

   function automatic logic fires(
      input logic [COUNT_WIDTH-1:0] cnt,
      input logic [LIMIT_WIDTH-1:0] limit
   );
      return CMP_WIDTH'(cnt) >= CMP_WIDTH'(limit);
   endfunction

   assign pop = head_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      avg_cnt_in      = avg_cnt_ff;
      best_cnt_in     = best_cnt_ff;
      avg_rel_cnt_in  = avg_rel_cnt_ff;
      best_rel_cnt_in = best_rel_cnt_ff;
      reason_in       = REASON_CONTINUE;
      go              = 1'b1;
      if (head_entry.cmd) begin
         // restart
         avg_cnt_in      = '0;
         best_cnt_in     = '0;
         avg_rel_cnt_in  = '0;
         best_rel_cnt_in = '0;
      end else begin
         if (cfg.enable_mask[EN_GENERATIONS] && head_entry.gen_hit) begin
            reason_in = REASON_GENERATIONS;
            go        = 1'b0;
         end
         if (go && cfg.enable_mask[EN_AVG_STALL]) begin
            avg_cnt_in = stall_next(avg_cnt_ff, head_entry.avg_abs_stall);
            if (fires(avg_cnt_in, cfg.stall_limit)) begin
               reason_in = REASON_AVG_STALL;
               go        = 1'b0;
            end
         end
         if (go && cfg.enable_mask[EN_BEST_STALL]) begin
            best_cnt_in = stall_next(best_cnt_ff, head_entry.best_abs_stall);
            if (fires(best_cnt_in, cfg.stall_limit)) begin
               reason_in = REASON_BEST_STALL;
               go        = 1'b0;
            end
         end
         if (go && cfg.enable_mask[EN_AVG_REL]) begin
            avg_rel_cnt_in = stall_next(avg_rel_cnt_ff, head_entry.avg_rel_stall);
            if (fires(avg_rel_cnt_in, cfg.stall_limit)) begin
               reason_in = REASON_AVG_REL;
               go        = 1'b0;
            end
         end
         if (go && cfg.enable_mask[EN_BEST_REL]) begin
            best_rel_cnt_in = stall_next(best_rel_cnt_ff, head_entry.best_rel_stall);
            if (fires(best_rel_cnt_in, cfg.stall_limit)) begin
               reason_in = REASON_BEST_REL;
               go        = 1'b0;
            end
         end
         if (go && cfg.enable_mask[EN_UPPER] && head_entry.upper_hit) begin
            reason_in = REASON_UPPER;
            go        = 1'b0;
         end
         if (go && cfg.enable_mask[EN_LOWER] && head_entry.lower_hit) begin
            reason_in = REASON_LOWER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_cnt_ff      <= '0;
         best_cnt_ff     <= '0;
         avg_rel_cnt_ff  <= '0;
         best_rel_cnt_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            avg_cnt_ff      <= avg_cnt_in;
            best_cnt_ff     <= best_cnt_in;
            avg_rel_cnt_ff  <= avg_rel_cnt_in;
            best_rel_cnt_ff <= best_rel_cnt_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         reason_ff <= reason_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.stop_reason = reason_ff;

endmodule

### tb/optimizer_stop_detector_test.sv
// optimizer_stop_detector_test: self-checking testbench with stop reason predictor and scoreboard
`timescale 1ns / 1ps

module optimizer_stop_detector_test import osd_pkg::*;;

   localparam int VW          = 32;
   localparam int CW          = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int REPORT_MAX  = 10;
   localparam logic signed [VW-1:0] TOP_VALUE    = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] BOTTOM_VALUE = {1'b1, {(VW-1){1'b0}}};

   typedef struct {
      logic                 cmd;
      logic [GEN_WIDTH-1:0] generation;
      logic signed [VW-1:0] old_best;
      logic signed [VW-1:0] new_best;
      logic signed [VW-1:0] old_average;
      logic signed [VW-1:0] new_average;
   } gen_report_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   osd_req_if #(.VALUE_WIDTH(VW)) req_bus ();
   osd_rsp_if                     rsp_bus ();

   optimizer_stop_detector #(
      .VALUE_WIDTH(VW),
      .COUNT_WIDTH(CW)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers and stall counters
   logic [MASK_WIDTH-1:0]           mask_cfg    = 7'd1;
   logic [GEN_WIDTH-1:0]            max_gen_cfg = 16'd1000;
   logic [ABS_TOL_WIDTH-1:0]        abs_tol_cfg = 31'd65;
   logic [REL_TOL_WIDTH-1:0]        rel_tol_cfg = 16'd66;
   logic [LIMIT_WIDTH-1:0]          limit_cfg   = 16'd50;
   logic signed [TARGET_WIDTH-1:0]  upper_cfg   = TOP_VALUE;
   logic signed [TARGET_WIDTH-1:0]  lower_cfg   = BOTTOM_VALUE;
   logic [CW-1:0] avg_run      = '0;
   logic [CW-1:0] best_run     = '0;
   logic [CW-1:0] avg_rel_run  = '0;
   logic [CW-1:0] best_rel_run = '0;

   reason_type expected_reasons[$];
   int         failures = 0;
   int         cycles   = 0;
   bit         gaps_on  = 1'b0;
   int         stall_left = 0;

   function automatic gen_report_type make_report(input logic cmd,
                                                  input logic [GEN_WIDTH-1:0] gen,
                                                  input logic signed [VW-1:0] ob, nb, oa, na);
      gen_report_type g;
      g.cmd         = cmd;
      g.generation  = gen;
      g.old_best    = ob;
      g.new_best    = nb;
      g.old_average = oa;
      g.new_average = na;
      return g;
   endfunction

   function automatic logic [VW:0] spread(input logic signed [VW-1:0] a, b);
      longint d;
      d = longint'(a) - longint'(b);
      return (VW+1)'((d < 0) ? -d : d);
   endfunction

   // |old - new| * 2^16 < rel_tol * |old|, exact in 64 bits
   function automatic logic rel_stall(input logic signed [VW-1:0] oldv, newv);
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic [63:0] mag;
      lhs = 64'(spread(oldv, newv)) << REL_FRAC_BITS;
      mag = (oldv < 0) ? -longint'(oldv) : longint'(oldv);
      rhs = 64'(rel_tol_cfg) * mag;
      return lhs < rhs;
   endfunction

   task automatic advance_run(inout logic [CW-1:0] run, input logic stalled,
                              output logic fired);
      if (stalled) begin
         if (run != '1) run = run + 1'b1;
      end else begin
         run = '0;
      end
      fired = run >= limit_cfg;
   endtask

   task automatic predict_stop(input gen_report_type g, output reason_type why);
      logic fired;
      why = REASON_CONTINUE;
      if (g.cmd) begin
         avg_run      = '0;
         best_run     = '0;
         avg_rel_run  = '0;
         best_rel_run = '0;
      end else begin
         if (mask_cfg[EN_GENERATIONS] && g.generation >= max_gen_cfg) why = REASON_GENERATIONS;
         if (why == REASON_CONTINUE && mask_cfg[EN_AVG_STALL]) begin
            advance_run(avg_run, spread(g.old_average, g.new_average) < abs_tol_cfg, fired);
            if (fired) why = REASON_AVG_STALL;
         end
         if (why == REASON_CONTINUE && mask_cfg[EN_BEST_STALL]) begin
            advance_run(best_run, spread(g.old_best, g.new_best) < abs_tol_cfg, fired);
            if (fired) why = REASON_BEST_STALL;
         end
         if (why == REASON_CONTINUE && mask_cfg[EN_AVG_REL]) begin
            advance_run(avg_rel_run, rel_stall(g.old_average, g.new_average), fired);
            if (fired) why = REASON_AVG_REL;
         end
         if (why == REASON_CONTINUE && mask_cfg[EN_BEST_REL]) begin
            advance_run(best_rel_run, rel_stall(g.old_best, g.new_best), fired);
            if (fired) why = REASON_BEST_REL;
         end
         if (why == REASON_CONTINUE && mask_cfg[EN_UPPER] && g.new_best >= upper_cfg)
            why = REASON_UPPER;
         if (why == REASON_CONTINUE && mask_cfg[EN_LOWER] && g.new_best <= lower_cfg)
            why = REASON_LOWER;
      end
   endtask

   task automatic log_failure(input string text);
      failures++;
      if (failures <= REPORT_MAX) $display("%0t: %s", $realtime, text);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_ENABLE_MASK:     mask_cfg    = value[MASK_WIDTH-1:0];
         CSR_MAX_GENERATIONS: max_gen_cfg = value[GEN_WIDTH-1:0];
         CSR_ABS_TOLERANCE:   abs_tol_cfg = value[ABS_TOL_WIDTH-1:0];
         CSR_REL_TOLERANCE:   rel_tol_cfg = value[REL_TOL_WIDTH-1:0];
         CSR_STALL_LIMIT:     limit_cfg   = value[LIMIT_WIDTH-1:0];
         CSR_UPPER_TARGET:    upper_cfg   = value;
         CSR_LOWER_TARGET:    lower_cfg   = value;
         default: ;
      endcase
   endtask

   task automatic send_report(input gen_report_type g);
      reason_type why;
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= g.cmd;
      req_bus.generation  <= g.generation;
      req_bus.old_best    <= g.old_best;
      req_bus.new_best    <= g.new_best;
      req_bus.old_average <= g.old_average;
      req_bus.new_average <= g.new_average;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_stop(g, why);
      expected_reasons.insert(expected_reasons.size(), why);
   endtask

   task automatic pause_sender(input int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (expected_reasons.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [VW-1:0] pick_value();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return TOP_VALUE;
         2: return BOTTOM_VALUE;
         3: return '1;
         4: return $signed(VW'($urandom_range(0, 1 << 20))) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [VW-1:0] nudge(input logic signed [VW-1:0] v);
      case ($urandom_range(0, 4))
         0: return v;
         1: return v + $signed(VW'($urandom_range(0, 127))) - 64;
         2: return v + (v >>> $urandom_range(4, 14));
         3: return v - (v >>> $urandom_range(4, 14));
         default: return pick_value();
      endcase
   endfunction

   // result side: random ready bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      reason_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_reasons.size() == 0) begin
            log_failure($sformatf("unexpected item, stop_reason %0d", rsp_bus.stop_reason));
         end else begin
            want = expected_reasons.pop_front();
            if (rsp_bus.stop_reason !== want)
               log_failure($sformatf("stop_reason expected %0d, got %0d",
                                     want, rsp_bus.stop_reason));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_report(make_report(1'b0, 16'd999, '0, '0, '0, '0));
      send_report(make_report(1'b0, 16'd1000, '0, '0, '0, '0));
      send_report(make_report(1'b0, 16'hFFFF, TOP_VALUE, BOTTOM_VALUE, BOTTOM_VALUE, TOP_VALUE));
      send_report(make_report(1'b1, 16'd0, '1, '1, '1, '1));
   endtask

   task automatic test_stall_counting();
      wait_drain();
      write_csr(CSR_ENABLE_MASK, (1 << EN_AVG_STALL) | (1 << EN_BEST_STALL));
      write_csr(CSR_ABS_TOLERANCE, 100);
      write_csr(CSR_STALL_LIMIT, 2);
      send_report(make_report(1'b0, 16'd1, '0, '0, '0, 32'sd99));
      send_report(make_report(1'b0, 16'd2, '0, '0, '0, 32'sd99));
      send_report(make_report(1'b0, 16'd3, '0, '0, '0, 32'sd100));
      send_report(make_report(1'b0, 16'd4, '0, '0, -32'sd50, 32'sd49));
      send_report(make_report(1'b1, 16'd5, '0, '0, '0, '0));
      send_report(make_report(1'b0, 16'd6, '0, '0, '0, '0));
   endtask

   task automatic test_priority_and_targets();
      wait_drain();
      write_csr(CSR_ENABLE_MASK, 32'h7F);
      write_csr(CSR_MAX_GENERATIONS, 32'hFFFF);
      write_csr(CSR_ABS_TOLERANCE, 0);
      write_csr(CSR_REL_TOLERANCE, 32'hFFFF);
      write_csr(CSR_STALL_LIMIT, 1);
      write_csr(CSR_UPPER_TARGET, TOP_VALUE);
      write_csr(CSR_LOWER_TARGET, BOTTOM_VALUE);
      send_report(make_report(1'b0, 16'hFFFF, '0, '0, '0, '0));
      send_report(make_report(1'b0, 16'd0, TOP_VALUE, TOP_VALUE, '0, '0));
      send_report(make_report(1'b0, 16'd1, '0, TOP_VALUE, BOTTOM_VALUE, TOP_VALUE));
      send_report(make_report(1'b0, 16'd2, '0, BOTTOM_VALUE, '0, 32'sd1));
      send_report(make_report(1'b0, 16'd3, 32'sd1, '0, '0, '0));
      wait_drain();
      write_csr(CSR_REL_TOLERANCE, 0);
      write_csr(CSR_ABS_TOLERANCE, 32'h7FFF_FFFF);
      send_report(make_report(1'b0, 16'd4, BOTTOM_VALUE, TOP_VALUE, TOP_VALUE, BOTTOM_VALUE));
      send_report(make_report(1'b0, 16'd5, BOTTOM_VALUE, TOP_VALUE, 32'sd5, 32'sd5));
   endtask

   task automatic test_zero_stall_limit();
      wait_drain();
      write_csr(CSR_ENABLE_MASK, 1 << EN_BEST_REL);
      write_csr(CSR_REL_TOLERANCE, 32'd4096);
      write_csr(CSR_STALL_LIMIT, 0);
      send_report(make_report(1'b0, 16'd7, '0, TOP_VALUE, '0, '0));
      send_report(make_report(1'b0, 16'd8, BOTTOM_VALUE, TOP_VALUE, '0, '0));
   endtask

   // a long stall run fires at the limit, then keeps firing while it goes on
   task automatic test_long_stall_run();
      logic signed [VW-1:0] v;
      wait_drain();
      write_csr(CSR_ENABLE_MASK, 1 << EN_AVG_STALL);
      write_csr(CSR_ABS_TOLERANCE, 32'h7FFF_FFFF);
      write_csr(CSR_STALL_LIMIT, 8);
      send_report(make_report(1'b1, 16'd0, '0, '0, '0, '0));
      for (int n = 0; n < 12; n++) begin
         v = $urandom;
         send_report(make_report(1'b0, GEN_WIDTH'(n), pick_value(), pick_value(), v, v));
      end
   endtask

   task automatic load_random_config(input int phase);
      wait_drain();
      if (phase == 0) begin
         write_csr(CSR_ENABLE_MASK, 32'h7E);
         write_csr(CSR_MAX_GENERATIONS, 0);
         write_csr(CSR_ABS_TOLERANCE, 0);
         write_csr(CSR_REL_TOLERANCE, 0);
         write_csr(CSR_STALL_LIMIT, 0);
         write_csr(CSR_UPPER_TARGET, BOTTOM_VALUE);
         write_csr(CSR_LOWER_TARGET, TOP_VALUE);
      end else if (phase == 1) begin
         write_csr(CSR_ENABLE_MASK, 32'h7F);
         write_csr(CSR_MAX_GENERATIONS, 32'hFFFF);
         write_csr(CSR_ABS_TOLERANCE, 32'h7FFF_FFFF);
         write_csr(CSR_REL_TOLERANCE, 32'hFFFF);
         write_csr(CSR_STALL_LIMIT, 32'hFFFF);
         write_csr(CSR_UPPER_TARGET, TOP_VALUE);
         write_csr(CSR_LOWER_TARGET, BOTTOM_VALUE);
      end else begin
         write_csr(CSR_ENABLE_MASK, $urandom_range(0, 127) & ($urandom_range(0, 1) ? 32'h7F
                                                                                   : 32'h7E));
         write_csr(CSR_MAX_GENERATIONS, $urandom_range(0, 3) ? $urandom_range(30, 300) : $urandom);
         write_csr(CSR_ABS_TOLERANCE, $urandom_range(0, 3) ? $urandom_range(0, 2000) : $urandom);
         write_csr(CSR_REL_TOLERANCE, $urandom_range(0, 3) ? $urandom_range(0, 4000) : $urandom);
         write_csr(CSR_STALL_LIMIT, $urandom_range(0, 5) ? $urandom_range(1, 6)
                                                        : $urandom_range(0, 65535));
         write_csr(CSR_UPPER_TARGET, $urandom_range(0, 1) ? TOP_VALUE - $urandom_range(0, 1 << 24)
                                                         : $urandom);
         write_csr(CSR_LOWER_TARGET, $urandom_range(0, 1) ? BOTTOM_VALUE + $urandom_range(0, 1 << 24)
                                                         : $urandom);
      end
   endtask

   // runs of consecutive generations with small changes, plus restarts and noise
   task automatic test_random_runs();
      logic [GEN_WIDTH-1:0] gen;
      logic signed [VW-1:0] best;
      logic signed [VW-1:0] avg;
      logic signed [VW-1:0] next_best;
      logic signed [VW-1:0] next_avg;
      gen_report_type       g;
      int                   roll;
      for (int phase = 0; phase < 8; phase++) begin
         load_random_config(phase);
         gaps_on = (phase < 6) && (phase != 3);
         gen  = $urandom_range(0, 40);
         best = pick_value();
         avg  = pick_value();
         for (int i = 0; i < 80; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
               g   = make_report(1'b1, GEN_WIDTH'($urandom), pick_value(), pick_value(),
                                 pick_value(), pick_value());
               gen = '0;
            end else if (roll < 15) begin
               g = make_report(1'b0, GEN_WIDTH'($urandom), pick_value(), pick_value(),
                               pick_value(), pick_value());
            end else begin
               next_best = nudge(best);
               next_avg  = nudge(avg);
               g    = make_report(1'b0, gen, best, next_best, avg, next_avg);
               best = next_best;
               avg  = next_avg;
               gen++;
            end
            if (gaps_on && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 13));
            if (i == 40 && phase[0]) wait_drain();
            send_report(g);
         end
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = 1'b0;
      req_bus.generation  = '0;
      req_bus.old_best    = '0;
      req_bus.new_best    = '0;
      req_bus.old_average = '0;
      req_bus.new_average = '0;
      rsp_bus.ready       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      gaps_on = 1'b1;
      test_reset_defaults();
      test_stall_counting();
      test_priority_and_targets();
      test_zero_stall_limit();
      gaps_on = 1'b0;
      test_long_stall_run();
      test_random_runs();
      wait_drain();
      repeat (10) @(posedge clock);
      if (failures == 0 && expected_reasons.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
